// ===== hdl/qcr_pkg.sv =====
`default_nettype none
package qcr_pkg;

  localparam int FracBits    = 14;
  localparam int CompWidth   = 16;
  localparam int ThreshReset = 97;
  localparam int CfgAddrW    = 3;
  localparam logic [CfgAddrW-1:0] RegRenormThreshold = 3'd0;

endpackage
`default_nettype wire

// ===== hdl/qcr_front.sv =====
`default_nettype none
// Front part: forms the saturated Hamilton product and decides renormalization.
module qcr_front #(
  parameter int FRAC_BITS  = qcr_pkg::FracBits,
  parameter int COMP_WIDTH = qcr_pkg::CompWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [7:0]                   thresh_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [COMP_WIDTH-1:0] a_w_i,
  input  wire  signed [COMP_WIDTH-1:0] a_x_i,
  input  wire  signed [COMP_WIDTH-1:0] a_y_i,
  input  wire  signed [COMP_WIDTH-1:0] a_z_i,
  input  wire  signed [COMP_WIDTH-1:0] b_w_i,
  input  wire  signed [COMP_WIDTH-1:0] b_x_i,
  input  wire  signed [COMP_WIDTH-1:0] b_y_i,
  input  wire  signed [COMP_WIDTH-1:0] b_z_i,
  output logic                         q_valid_o,
  input  wire                          q_ready_i,
  output logic [4*COMP_WIDTH:0]        q_data_o
);
  localparam int PW = 2 * COMP_WIDTH;
  localparam int SW = PW + 3;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StOut  = 3'b100
  } st_e;

  st_e st_q, st_d;
  logic [1:0] comp_q;
  logic signed [COMP_WIDTH-1:0] a_q [4];
  logic signed [COMP_WIDTH-1:0] b_q [4];
  logic signed [COMP_WIDTH-1:0] r_q [4];
  logic [7:0] cnt_q;
  logic       renorm_q;

  // per-component operand selection: term k uses a[ia[k]]*b[ib[k]], subtracted when neg[k] is set
  logic [1:0] ia [4];
  logic [1:0] ib [4];
  logic [3:0] neg;
  always_comb begin
    case (comp_q)
      2'd0: begin
        ia[0] = 2'd0; ib[0] = 2'd0; ia[1] = 2'd1; ib[1] = 2'd1;
        ia[2] = 2'd2; ib[2] = 2'd2; ia[3] = 2'd3; ib[3] = 2'd3; neg = 4'b1110;
      end
      2'd1: begin
        ia[0] = 2'd2; ib[0] = 2'd3; ia[1] = 2'd3; ib[1] = 2'd2;
        ia[2] = 2'd1; ib[2] = 2'd0; ia[3] = 2'd0; ib[3] = 2'd1; neg = 4'b0010;
      end
      2'd2: begin
        ia[0] = 2'd3; ib[0] = 2'd1; ia[1] = 2'd1; ib[1] = 2'd3;
        ia[2] = 2'd2; ib[2] = 2'd0; ia[3] = 2'd0; ib[3] = 2'd2; neg = 4'b0010;
      end
      default: begin
        ia[0] = 2'd1; ib[0] = 2'd2; ia[1] = 2'd2; ib[1] = 2'd1;
        ia[2] = 2'd3; ib[2] = 2'd0; ia[3] = 2'd0; ib[3] = 2'd3; neg = 4'b0010;
      end
    endcase
  end

  logic signed [SW-1:0] sum;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] term;
  logic signed [COMP_WIDTH-1:0] sat_v;
  localparam logic signed [SW-1:0] Hi = SW'((64'sd1 <<< (COMP_WIDTH - 1)) - 1);
  localparam logic signed [SW-1:0] Lo = -Hi - SW'(1);
  always_comb begin
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      prod = a_q[ia[k]] * b_q[ib[k]];
      term = SW'(prod >>> FRAC_BITS);
      sum  = neg[k] ? sum - term : sum + term;
    end
    if (sum > Hi) sat_v = Hi[COMP_WIDTH-1:0];
    else if (sum < Lo) sat_v = Lo[COMP_WIDTH-1:0];
    else sat_v = sum[COMP_WIDTH-1:0];
  end

  logic [8:0] nxt;
  assign nxt = {1'b0, cnt_q} + 9'd1;
  logic acc;
  assign in_ready_o = (st_q == StIdle);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (in_valid_i) st_d = StMul;
      StMul:   if (comp_q == 2'd3) st_d = StOut;
      StOut:   if (q_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      comp_q   <= '0;
      cnt_q    <= '0;
      renorm_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (acc) begin
        comp_q <= '0;
        if (nxt > {1'b0, thresh_i}) begin
          cnt_q    <= '0;
          renorm_q <= 1'b1;
        end else begin
          cnt_q    <= nxt[7:0];
          renorm_q <= 1'b0;
        end
      end else if (st_q == StMul) begin
        comp_q <= comp_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_q[0] <= a_w_i; a_q[1] <= a_x_i; a_q[2] <= a_y_i; a_q[3] <= a_z_i;
      b_q[0] <= b_w_i; b_q[1] <= b_x_i; b_q[2] <= b_y_i; b_q[3] <= b_z_i;
    end
    if (st_q == StMul) r_q[comp_q] <= sat_v;
  end

  assign q_valid_o = (st_q == StOut);
  assign q_data_o  = {renorm_q, r_q[0], r_q[1], r_q[2], r_q[3]};
endmodule
`default_nettype wire

// ===== hdl/qcr_queue.sv =====
`default_nettype none
module qcr_queue #(
  parameter int W = 65
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire  [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output logic [W-1:0] out_data_o
);
  logic [W-1:0] mem_q [2];
  logic [1:0] cnt_q;
  logic wp_q, rp_q;
  logic push, pop;
  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule
`default_nettype wire

// ===== hdl/qcr_back.sv =====
`default_nettype none
// Back part: flagged items get sum of squares, bit-serial root and restoring divides.
module qcr_back #(
  parameter int FRAC_BITS  = qcr_pkg::FracBits,
  parameter int COMP_WIDTH = qcr_pkg::CompWidth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   q_valid_i,
  output logic                  q_ready_o,
  input  wire  [4*COMP_WIDTH:0] q_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output logic [COMP_WIDTH-1:0] r_w_o,
  output logic [COMP_WIDTH-1:0] r_x_o,
  output logic [COMP_WIDTH-1:0] r_y_o,
  output logic [COMP_WIDTH-1:0] r_z_o,
  output logic                  renormalized_o
);
  localparam int CW  = COMP_WIDTH;
  localparam int SQW = 2 * CW + 2;        // sum of four squares
  localparam int RW  = SQW / 2;           // root width
  localparam int NW  = CW + FRAC_BITS;    // dividend width
  localparam int QW  = NW + 1;
  localparam int RCW = $clog2(RW + 1);
  localparam int DCW = $clog2(NW + 1);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StSq   = 6'b000010,
    StRoot = 6'b000100,
    StDiv  = 6'b001000,
    StFix  = 6'b010000,
    StOut  = 6'b100000
  } st_e;

  st_e st_q, st_d;
  logic signed [CW-1:0] r_q [4];
  logic [1:0] idx_q;
  logic [SQW-1:0] s_q;
  logic [RW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [RCW-1:0] rcnt_q;
  logic [NW-1:0] num_q;
  logic [RW:0] drem_q;
  logic [DCW-1:0] dcnt_q;
  logic flag_q;

  logic [CW-1:0] mag;
  assign mag = r_q[idx_q][CW-1] ? CW'(-r_q[idx_q]) : r_q[idx_q];

  // root step
  logic [RW+1:0] rem_sh, trial;
  assign rem_sh = {rem_q[RW-1:0], s_q[SQW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // divide step: dividend bit shifted into partial remainder
  logic [RW+1:0] dsh;
  assign dsh = {drem_q, num_q[NW-1]};
  logic dge;
  assign dge = dsh >= {2'b00, root_q};

  logic [QW-1:0] qval;
  logic [RW+1:0] qrnd;
  logic [CW-1:0] satq;
  localparam logic [QW-1:0] MaxP = QW'((64'd1 << (CW - 1)) - 1);
  always_comb begin
    // num_q holds quotient q; drem_q remainder rem; divisor m is root_q. round:
    // (num + floor(m/2)) / m = q + (rem + floor(m/2) >= m)
    qrnd = {1'b0, drem_q} + {2'b00, 1'b0, root_q[RW-1:1]};
    qval = {1'b0, num_q} + QW'(qrnd >= {2'b00, root_q});
    if (r_q[idx_q][CW-1]) begin
      if (qval > MaxP + QW'(1)) satq = {1'b1, {(CW-1){1'b0}}};
      else satq = CW'(-qval);
    end else begin
      if (qval > MaxP) satq = MaxP[CW-1:0];
      else satq = qval[CW-1:0];
    end
  end

  assign q_ready_o = (st_q == StIdle);
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = q_data_i[4*CW] ? StSq : StOut;
      StSq:   if (idx_q == 2'd3) st_d = StRoot;
      StRoot: if (rcnt_q == RCW'(RW - 1)) st_d = StDiv;
      StDiv:  if (root_q == '0) st_d = StOut;
              else if (dcnt_q == DCW'(NW)) st_d = StFix;
      StFix:  st_d = (idx_q == 2'd3) ? StOut : StDiv;
      StOut:  if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      idx_q <= '0;
      rcnt_q <= '0;
      dcnt_q <= '0;
      flag_q <= 1'b0;
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle: begin
          idx_q <= '0;
          rcnt_q <= '0;
          flag_q <= 1'b0;
        end
        StSq: idx_q <= idx_q + 2'd1;
        StRoot: begin
          rcnt_q <= rcnt_q + RCW'(1);
          if (rcnt_q == RCW'(RW - 1)) begin
            idx_q <= '0;
            dcnt_q <= '0;
          end
        end
        StDiv: dcnt_q <= dcnt_q + DCW'(1);
        StFix: begin
          idx_q <= idx_q + 2'd1;
          dcnt_q <= '0;
          flag_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        r_q[0] <= q_data_i[4*CW-1 -: CW];
        r_q[1] <= q_data_i[3*CW-1 -: CW];
        r_q[2] <= q_data_i[2*CW-1 -: CW];
        r_q[3] <= q_data_i[CW-1 -: CW];
        s_q <= '0;
        rem_q <= '0;
        root_q <= '0;
      end
      StSq: begin
        s_q <= s_q + SQW'(mag * mag);
        if (idx_q == 2'd3) begin
          num_q <= '0;
        end
      end
      StRoot: begin
        s_q <= s_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[RW-2:0], 1'b0};
        end
        if (rcnt_q == RCW'(RW - 1)) begin
          drem_q <= '0;
        end
      end
      StDiv: begin
        if (dcnt_q == '0) begin
          num_q  <= {mag, {FRAC_BITS{1'b0}}};
          drem_q <= '0;
        end else begin
          num_q <= {num_q[NW-2:0], dge};
          drem_q <= dge ? (RW+1)'(dsh - {2'b00, root_q}) : dsh[RW:0];
        end
      end
      StFix: r_q[idx_q] <= satq;
      default: ;
    endcase
  end

  assign out_valid_o    = (st_q == StOut);
  assign r_w_o          = r_q[0];
  assign r_x_o          = r_q[1];
  assign r_y_o          = r_q[2];
  assign r_z_o          = r_q[3];
  assign renormalized_o = flag_q;
endmodule
`default_nettype wire

// ===== hdl/quaternion_compose_renormalize_core.sv =====
// Quaternion compose with periodic renormalization.
// Input channel (in_valid_i/in_ready_o) takes two Q2.14 quaternions a and b;
// output channel (out_valid_o/out_ready_i) returns their saturated Hamilton
// product r and a renormalized flag. An item is moved when valid and ready
// are both high.
// The front computes one product component per cycle (four multipliers) and
// takes no new item until the last one has left it. A two-entry queue
// separates it from the back. Plain items go from the back's idle state straight
// to its output. Every threshold+1 items one is renormalized: squares summed,
// bit-serial root taken, then each component restoring-divided by the root.
// renorm_threshold is written through the APB port at address 0 (reset 97).
// Reset clears the call counter, the queue and both state machines.
// When the receiver stalls, the result holds on the output, the queue fills,
// and then in_ready_o drops.
`default_nettype none
module quaternion_compose_renormalize_core #(
  parameter int FRAC_BITS  = qcr_pkg::FracBits,
  parameter int COMP_WIDTH = qcr_pkg::CompWidth
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [qcr_pkg::CfgAddrW-1:0] paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [COMP_WIDTH-1:0] a_w_i,
  input  wire  signed [COMP_WIDTH-1:0] a_x_i,
  input  wire  signed [COMP_WIDTH-1:0] a_y_i,
  input  wire  signed [COMP_WIDTH-1:0] a_z_i,
  input  wire  signed [COMP_WIDTH-1:0] b_w_i,
  input  wire  signed [COMP_WIDTH-1:0] b_x_i,
  input  wire  signed [COMP_WIDTH-1:0] b_y_i,
  input  wire  signed [COMP_WIDTH-1:0] b_z_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [COMP_WIDTH-1:0] r_w_o,
  output logic signed [COMP_WIDTH-1:0] r_x_o,
  output logic signed [COMP_WIDTH-1:0] r_y_o,
  output logic signed [COMP_WIDTH-1:0] r_z_o,
  output logic                         renormalized_o
);
  localparam int DW = 4 * COMP_WIDTH + 1;

  logic [7:0] thresh_q;
  assign pready = 1'b1;
  assign prdata = (paddr == qcr_pkg::RegRenormThreshold) ? {24'd0, thresh_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 8'(qcr_pkg::ThreshReset);
    end else if (psel && penable && pwrite && paddr == qcr_pkg::RegRenormThreshold) begin
      thresh_q <= pwdata[7:0];
    end
  end

  logic f_valid, f_ready, b_valid, b_ready;
  logic [DW-1:0] f_data, b_data;

  qcr_front #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_front (
    .clk_i, .rst_ni, .thresh_i(thresh_q), .in_valid_i, .in_ready_o,
    .a_w_i, .a_x_i, .a_y_i, .a_z_i, .b_w_i, .b_x_i, .b_y_i, .b_z_i,
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_data_o(f_data)
  );

  qcr_queue #(.W(DW)) u_queue (
    .clk_i, .rst_ni, .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_data),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_data)
  );

  qcr_back #(.FRAC_BITS(FRAC_BITS), .COMP_WIDTH(COMP_WIDTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(b_valid), .q_ready_o(b_ready), .q_data_i(b_data),
    .out_valid_o, .out_ready_i, .r_w_o, .r_x_o, .r_y_o, .r_z_o, .renormalized_o
  );
endmodule
`default_nettype wire
